/* rtl/lzwd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LZW code decoder package
// Shared constants, error codes and the result record passed to the output
// register.
// ----------------------------------------------------------------------------
package lzwd_pkg;

   // Codes below this value are literal bytes.
   localparam int LITERAL_COUNT = 256;

   // Bytes carried by one result.
   localparam int BYTES_PER_RSP = 8;
   localparam int COUNT_W       = 4;

   // Result data word: eight bytes, then the byte count, padded to whole bytes.
   localparam int RSP_DATA_W = ((BYTES_PER_RSP * 8 + COUNT_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - BYTES_PER_RSP * 8 - COUNT_W;

   // Error kinds reported in tuser.
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_INVALID  = 2'd1;
   localparam logic [1:0] ERR_TOO_LONG = 2'd2;
   localparam logic [1:0] ERR_HALTED   = 2'd3;

   typedef struct packed {
      logic [1:0]                          error_kind;
      logic                                last_of_code;
      logic [COUNT_W-1:0]                  byte_count;
      logic [BYTES_PER_RSP-1:0][7:0]       data_bytes;
   } rsp_type;

endpackage : lzwd_pkg
`default_nettype wire

/* rtl/lzw_code_decoder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sequence: after acceptance the walk follows the prefix chain of a code, one dictionary read
//   per linked entry, down to the root literal, pushing tail bytes on the byte stack; the unwind
//   then pops the stack into results. Invalid, halted and too-long codes load a single error result.
// One code at a time: a new code is taken only once the previous one has loaded its last
//   result into the output register. A result waiting on rsp_tready stalls the unwind.
// Reset is synchronous and active high; it clears control state only, so requests are taken at once.
// ----------------------------------------------------------------------------
// LZW code decoder unit
// Expands one LZW code per request into its bytes, up to eight bytes per result,
// keeping the dictionary as prefix links and tail bytes in a synchronous RAM.
// ----------------------------------------------------------------------------
module lzw_code_decoder_unit #(
   parameter int CODE_BITS     = 12,
   parameter int TABLE_ENTRIES = 4096,
   parameter int MAX_STRING    = 512,
   localparam int REQ_DATA_W   = ((CODE_BITS + 7) / 8) * 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request stream.
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // req_tdata, from bit 0 up: code_word, zero padding
   input  wire logic [REQ_DATA_W-1:0]         req_tdata,
   // Result stream.
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // rsp_tdata, from bit 0 up: byte_a .. byte_h, byte_count, zero padding
   output logic [lzwd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // rsp_tlast: last_of_code
   output logic                               rsp_tlast,
   // rsp_tuser, from bit 0 up: error_kind
   output logic [1:0]                         rsp_tuser
);
   import lzwd_pkg::*;

   // Width of the dictionary address, the free pointer (which can hold the
   // table size itself to mean "full"), the stack fill and the stack address.
   localparam int ADDR_W = $clog2(TABLE_ENTRIES);
   localparam int NF_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int FILL_W = $clog2(MAX_STRING + 1);
   localparam int SP_W   = $clog2(MAX_STRING);
   localparam int TAB_W  = CODE_BITS + 8;
   localparam int BIDX_W = $clog2(BYTES_PER_RSP);

   localparam logic [31:0] LIT_LIM   = 32'(LITERAL_COUNT);
   localparam logic [31:0] TABLE_LIM = 32'(TABLE_ENTRIES);
   localparam logic [31:0] STR_LIM   = 32'(MAX_STRING);

   // Sequencer states.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_POP  = 2'd2;
   localparam logic [1:0] S_ERR  = 2'd3;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   logic [1:0]            state_ff, state_in;
   logic [NF_W-1:0]       next_free_ff, next_free_in;
   logic                  wrapped_ff, wrapped_in;
   logic [CODE_BITS-1:0]  prev_code_ff, prev_code_in;
   logic [7:0]            prev_first_ff, prev_first_in;
   logic                  awaiting_ff, awaiting_in;
   logic                  halted_ff, halted_in;
   logic                  tab_pend_ff, tab_pend_in;
   logic                  stk_pend_ff, stk_pend_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [FILL_W-1:0]     rem_ff, rem_in;
   logic [COUNT_W-1:0]    cnt_ff, cnt_in;

   // Payload registers (no reset needed).
   logic [CODE_BITS-1:0]            code_ff, code_in;
   logic                            kwk_ff, kwk_in;
   logic [CODE_BITS-1:0]            cur_ff, cur_in;
   logic [1:0]                      err_kind_ff, err_kind_in;
   logic [SP_W-1:0]                 rd_ptr_ff, rd_ptr_in;
   logic [BYTES_PER_RSP-1:0][7:0]   buf_ff, buf_in;

   // ------------------------------------------------------------------
   // Memories: dictionary entries {prefix link, tail byte} and byte stack
   // ------------------------------------------------------------------
   logic [TAB_W-1:0]  tab_mem [TABLE_ENTRIES];
   logic [TAB_W-1:0]  tab_q_ff;
   logic              tab_we, tab_re;
   logic [ADDR_W-1:0] tab_waddr, tab_raddr;
   logic [TAB_W-1:0]  tab_wdata;

   logic [7:0]        stk_mem [MAX_STRING];
   logic [7:0]        stk_q_ff;
   logic              stk_we, stk_re;
   logic [SP_W-1:0]   stk_waddr, stk_raddr;
   logic [7:0]        stk_wdata;

   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[tab_waddr] <= tab_wdata;
      end
      if (tab_re) begin
         tab_q_ff <= tab_mem[tab_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_q_ff <= stk_mem[stk_raddr];
      end
   end

   // ------------------------------------------------------------------
   // Code checks on the incoming request
   // ------------------------------------------------------------------
   logic [CODE_BITS-1:0] code_w;
   logic [31:0]          code32, nf32;
   logic                 lit_w, in_table_w, kwk_w, valid_w, invalid_w;
   logic                 req_fire;

   assign code_w     = req_tdata[CODE_BITS-1:0];
   assign code32     = 32'(code_w);
   assign nf32       = 32'(next_free_ff);
   assign lit_w      = code32 < LIT_LIM;
   assign in_table_w = code32 < TABLE_LIM;
   // A code equal to the next free slot refers to the entry about to be made.
   assign kwk_w      = !awaiting_ff && (code32 == nf32);
   assign valid_w    = in_table_w && (lit_w || (code32 < nf32) || wrapped_ff);
   assign invalid_w  = !in_table_w || (awaiting_ff && !lit_w) || (!kwk_w && !valid_w);

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // ------------------------------------------------------------------
   // Chain walk: each cycle either starts from the stored code or follows the
   // link returned by the previous dictionary read, whose tail byte is pushed.
   // ------------------------------------------------------------------
   logic [FILL_W-1:0]    fill_now;
   logic [CODE_BITS-1:0] c_now;
   logic [31:0]          c32, fill32;
   logic [7:0]           first_w;
   logic [NF_W-1:0]      slot_w, slot_next_w;

   assign fill_now    = fill_ff + FILL_W'(tab_pend_ff);
   assign c_now       = tab_pend_ff ? tab_q_ff[TAB_W-1:8] : cur_ff;
   assign c32         = 32'(c_now);
   assign fill32      = 32'(fill_now);
   assign first_w     = kwk_ff ? prev_first_ff : c_now[7:0];
   // A full table wraps its fill point back to the first non-literal code.
   assign slot_w      = (nf32 >= TABLE_LIM) ? NF_W'(LITERAL_COUNT) : next_free_ff;
   assign slot_next_w = slot_w + NF_W'(1);

   // ------------------------------------------------------------------
   // Stack unwind: one stack byte per cycle into the result buffer, held while it is full and stalled.
   // ------------------------------------------------------------------
   logic [BYTES_PER_RSP-1:0][7:0] buf_a;
   logic [COUNT_W-1:0]            cnt_a;
   logic [FILL_W-1:0]             rem_a;
   logic                          full_w, done_w, flush_ok;
   logic                          rsp_free, rsp_load;
   rsp_type                       rsp_next;

   always_comb begin
      buf_a = buf_ff;
      if (stk_pend_ff) begin
         buf_a[cnt_ff[BIDX_W-1:0]] = stk_q_ff;
      end
   end

   assign cnt_a    = cnt_ff + COUNT_W'(stk_pend_ff);
   assign rem_a    = rem_ff - FILL_W'(stk_pend_ff);
   assign full_w   = (cnt_a == COUNT_W'(BYTES_PER_RSP));
   assign done_w   = (rem_a == '0);
   assign flush_ok = (full_w || done_w) && rsp_free;

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      next_free_in  = next_free_ff;
      wrapped_in    = wrapped_ff;
      prev_code_in  = prev_code_ff;
      prev_first_in = prev_first_ff;
      awaiting_in   = awaiting_ff;
      halted_in     = halted_ff;
      tab_pend_in   = 1'b0;
      stk_pend_in   = 1'b0;
      fill_in       = fill_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      code_in       = code_ff;
      kwk_in        = kwk_ff;
      cur_in        = cur_ff;
      err_kind_in   = err_kind_ff;
      rd_ptr_in     = rd_ptr_ff;
      buf_in        = buf_ff;

      tab_we    = 1'b0;
      tab_re    = 1'b0;
      tab_waddr = '0;
      tab_raddr = '0;
      tab_wdata = '0;
      stk_we    = 1'b0;
      stk_re    = 1'b0;
      stk_waddr = '0;
      stk_raddr = '0;
      stk_wdata = '0;

      rsp_load  = 1'b0;
      rsp_next  = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               code_in = code_w;
               kwk_in  = kwk_w;
               if (halted_ff) begin
                  err_kind_in = ERR_HALTED;
                  state_in    = S_ERR;
               end else if (invalid_w) begin
                  halted_in   = 1'b1;
                  err_kind_in = ERR_INVALID;
                  state_in    = S_ERR;
               end else if (kwk_w) begin
                  // The string ends in the first byte of the previous string.
                  stk_we    = 1'b1;
                  stk_waddr = '0;
                  stk_wdata = prev_first_ff;
                  fill_in   = FILL_W'(1);
                  cur_in    = prev_code_ff;
                  state_in  = S_WALK;
               end else begin
                  fill_in  = '0;
                  cur_in   = code_w;
                  state_in = S_WALK;
               end
            end
         end

         S_WALK: begin
            if (tab_pend_ff) begin
               stk_we    = 1'b1;
               stk_waddr = fill_ff[SP_W-1:0];
               stk_wdata = tab_q_ff[7:0];
            end
            if (c32 >= LIT_LIM) begin
               if ((fill32 >= STR_LIM) || (c32 >= TABLE_LIM)) begin
                  halted_in   = 1'b1;
                  err_kind_in = ERR_TOO_LONG;
                  state_in    = S_ERR;
               end else begin
                  tab_re      = 1'b1;
                  tab_raddr   = ADDR_W'(c_now);
                  tab_pend_in = 1'b1;
                  fill_in     = fill_now;
               end
            end else if (fill32 >= STR_LIM) begin
               halted_in   = 1'b1;
               err_kind_in = ERR_TOO_LONG;
               state_in    = S_ERR;
            end else begin
               // Reached the root literal: commit the dictionary update unless no code came before, and
               // start the unwind with the root as the first output byte.
               if (!awaiting_ff) begin
                  tab_we       = 1'b1;
                  tab_waddr    = ADDR_W'(slot_w);
                  tab_wdata    = {prev_code_ff, first_w};
                  next_free_in = slot_next_w;
                  if (32'(slot_next_w) >= TABLE_LIM) begin
                     wrapped_in = 1'b1;
                  end
               end
               prev_code_in  = code_ff;
               prev_first_in = first_w;
               awaiting_in   = 1'b0;
               buf_in        = '0;
               buf_in[0]     = c_now[7:0];
               cnt_in        = COUNT_W'(1);
               rem_in        = fill_now;
               rd_ptr_in     = SP_W'(fill_now - FILL_W'(1));
               state_in      = S_POP;
            end
         end

         S_POP: begin
            rem_in = rem_a;
            if (flush_ok) begin
               rsp_load                = 1'b1;
               rsp_next.data_bytes     = buf_a;
               rsp_next.byte_count     = cnt_a;
               rsp_next.last_of_code   = done_w;
               rsp_next.error_kind     = ERR_NONE;
               cnt_in                  = '0;
               buf_in                  = '0;
               if (done_w) begin
                  state_in = S_IDLE;
               end
            end else begin
               cnt_in = cnt_a;
               buf_in = buf_a;
            end
            // At most one stack read in flight, and only while the buffer has room.
            if (!done_w && (!full_w || flush_ok)) begin
               stk_re      = 1'b1;
               stk_raddr   = rd_ptr_ff;
               rd_ptr_in   = rd_ptr_ff - SP_W'(1);
               stk_pend_in = 1'b1;
            end
         end

         S_ERR: begin
            if (rsp_free) begin
               rsp_load              = 1'b1;
               rsp_next.last_of_code = 1'b1;
               rsp_next.error_kind   = err_kind_ff;
               state_in              = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         next_free_ff  <= NF_W'(LITERAL_COUNT);
         wrapped_ff    <= 1'b0;
         prev_code_ff  <= '0;
         prev_first_ff <= '0;
         awaiting_ff   <= 1'b1;
         halted_ff     <= 1'b0;
         tab_pend_ff   <= 1'b0;
         stk_pend_ff   <= 1'b0;
         fill_ff       <= '0;
         rem_ff        <= '0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         next_free_ff  <= next_free_in;
         wrapped_ff    <= wrapped_in;
         prev_code_ff  <= prev_code_in;
         prev_first_ff <= prev_first_in;
         awaiting_ff   <= awaiting_in;
         halted_ff     <= halted_in;
         tab_pend_ff   <= tab_pend_in;
         stk_pend_ff   <= stk_pend_in;
         fill_ff       <= fill_in;
         rem_ff        <= rem_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      kwk_ff      <= kwk_in;
      cur_ff      <= cur_in;
      err_kind_ff <= err_kind_in;
      rd_ptr_ff   <= rd_ptr_in;
      buf_ff      <= buf_in;
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   lzwd_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (rsp_load),
      .rsp_in     (rsp_next),
      .free       (rsp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule : lzw_code_decoder_unit
`default_nettype wire

/* rtl/lzwd_rsp_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LZW decoder result register
// Holds one finished result on the output stream so the decoder core can go
// on with the next request while the result waits to be taken.
// ----------------------------------------------------------------------------
module lzwd_rsp_reg (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire lzwd_pkg::rsp_type             rsp_in,
   output logic                               free,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // rsp_tdata, from bit 0 up: byte_a .. byte_h, byte_count, zero padding
   output logic [lzwd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   // rsp_tuser, from bit 0 up: error_kind
   output logic [1:0]                         rsp_tuser
);
   import lzwd_pkg::*;

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;

   // The register can take a new result when it is empty or being drained.
   assign free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_data_ff.byte_count, rsp_data_ff.data_bytes};
   assign rsp_tlast  = rsp_data_ff.last_of_code;
   assign rsp_tuser  = rsp_data_ff.error_kind;

endmodule : lzwd_rsp_reg
`default_nettype wire
